// ----- sv/cwd_pkg.sv -----
package cwd_pkg;

  localparam int unsigned WeightWidth = 24;
  localparam int unsigned StampWidth  = 32;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned ValueWidth  = 9;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxWidth-1:0] REG_CHANGE_THRESHOLD = 8'd0;
  localparam logic [CfgIdxWidth-1:0] REG_STABLE_DELTA     = 8'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SETTLE_TIME      = 8'd2;
  localparam logic [CfgIdxWidth-1:0] REG_COOL_TIME        = 8'd3;

  localparam logic [CfgWidth-1:0] RST_CHANGE_THRESHOLD = 16'd50;
  localparam logic [CfgWidth-1:0] RST_STABLE_DELTA     = 16'd10;
  localparam logic [CfgWidth-1:0] RST_SETTLE_TIME      = 16'd1000;
  localparam logic [CfgWidth-1:0] RST_COOL_TIME        = 16'd3000;

  // Coin band edges in centigrams, lower bound inclusive, upper exclusive.
  localparam logic signed [WeightWidth-1:0] BAND_1_LO   = 24'sd70;
  localparam logic signed [WeightWidth-1:0] BAND_1_HI   = 24'sd150;
  localparam logic signed [WeightWidth-1:0] BAND_5_LO   = 24'sd330;
  localparam logic signed [WeightWidth-1:0] BAND_50_LO  = 24'sd380;
  localparam logic signed [WeightWidth-1:0] BAND_10_LO  = 24'sd420;
  localparam logic signed [WeightWidth-1:0] BAND_100_LO = 24'sd465;
  localparam logic signed [WeightWidth-1:0] BAND_100_HI = 24'sd550;
  localparam logic signed [WeightWidth-1:0] BAND_500_LO = 24'sd650;
  localparam logic signed [WeightWidth-1:0] BAND_500_HI = 24'sd750;

  localparam logic [ValueWidth-1:0] COIN_NONE = 9'd0;
  localparam logic [ValueWidth-1:0] COIN_1    = 9'd1;
  localparam logic [ValueWidth-1:0] COIN_5    = 9'd5;
  localparam logic [ValueWidth-1:0] COIN_10   = 9'd10;
  localparam logic [ValueWidth-1:0] COIN_50   = 9'd50;
  localparam logic [ValueWidth-1:0] COIN_100  = 9'd100;
  localparam logic [ValueWidth-1:0] COIN_500  = 9'd500;

  localparam logic [1:0] PHASE_CODE_WAIT   = 2'd0;
  localparam logic [1:0] PHASE_CODE_DETECT = 2'd1;
  localparam logic [1:0] PHASE_CODE_COOL   = 2'd2;

  // Result item, coin_found in the lowest bit.
  typedef struct packed {
    logic [1:0]            phase_now;
    logic                  tare_request;
    logic                  reject;
    logic [ValueWidth-1:0] coin_value;
    logic                  coin_found;
  } cwd_result_t;

endpackage

// ----- sv/cwd_classify.sv -----
module cwd_classify
  import cwd_pkg::*;
(
  input  logic signed [WeightWidth-1:0] weight,
  output logic        [ValueWidth-1:0]  value
);

  always_comb begin
    if (weight >= BAND_1_LO && weight < BAND_1_HI) begin
      value = COIN_1;
    end else if (weight >= BAND_5_LO && weight < BAND_50_LO) begin
      value = COIN_5;
    end else if (weight >= BAND_50_LO && weight < BAND_10_LO) begin
      value = COIN_50;
    end else if (weight >= BAND_10_LO && weight < BAND_100_LO) begin
      value = COIN_10;
    end else if (weight >= BAND_100_LO && weight < BAND_100_HI) begin
      value = COIN_100;
    end else if (weight >= BAND_500_LO && weight < BAND_500_HI) begin
      value = COIN_500;
    end else begin
      value = COIN_NONE;
    end
  end

endmodule

// ----- sv/coin_weight_detector_core.sv -----
// An accepted input transaction reaches the output through one input register
// and then one result register.
// Throughput: one sample per cycle while m_tready holds; the phase machine updates its state in the
// same cycle the sample leaves the input register.
// Reset (rst, synchronous): phase waiting, weight and stamps zero, registers
// at their defaults, both pipeline registers empty.
module coin_weight_detector_core
  import cwd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: [23:0] sample_weight, [55:24] now_ms
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [55:0]            s_tdata,
  // m_tdata: [0] coin_found, [9:1] coin_value, [10] reject, [11] tare_request,
  // [13:12] phase_now, [15:14] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    PH_WAIT   = PHASE_CODE_WAIT,
    PH_DETECT = PHASE_CODE_DETECT,
    PH_COOL   = PHASE_CODE_COOL
  } phase_t;

  logic [CfgWidth-1:0] change_threshold;
  logic [CfgWidth-1:0] stable_delta;
  logic [CfgWidth-1:0] settle_time;
  logic [CfgWidth-1:0] cool_time;

  phase_t                       phase, phase_next;
  logic signed [WeightWidth-1:0] previous_weight, previous_weight_next;
  logic [StampWidth-1:0]        change_stamp, change_stamp_next;
  logic [StampWidth-1:0]        coin_stamp, coin_stamp_next;

  logic                          in_valid;
  logic signed [WeightWidth-1:0] in_weight;
  logic [StampWidth-1:0]         in_now;

  logic        out_valid;
  cwd_result_t out_result, result_next;

  logic                           advance;
  logic signed [WeightWidth:0]    diff;
  logic [WeightWidth:0]           step;
  logic [StampWidth-1:0]          since_change;
  logic [StampWidth-1:0]          since_coin;
  logic [ValueWidth-1:0]          coin;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {2'b00, out_result};
  assign cfg_ready = 1'b1;

  assign diff = {in_weight[WeightWidth-1], in_weight}
              - {previous_weight[WeightWidth-1], previous_weight};
  assign step = diff[WeightWidth] ? (~diff + 1'b1) : diff;
  assign since_change = in_now - change_stamp;
  assign since_coin   = in_now - coin_stamp;

  cwd_classify u_classify (
    .weight (in_weight),
    .value  (coin)
  );

  always_comb begin
    phase_next           = phase;
    previous_weight_next = previous_weight;
    change_stamp_next    = change_stamp;
    coin_stamp_next      = coin_stamp;
    result_next          = '0;
    case (phase)
      PH_DETECT: begin
        previous_weight_next = in_weight;
        if (step < {{(WeightWidth + 1 - CfgWidth){1'b0}}, stable_delta}) begin
          if (since_change > {{(StampWidth - CfgWidth){1'b0}}, settle_time}) begin
            result_next.tare_request = 1'b1;
            // The tare re-zeroes the scale, so the next step is taken from zero.
            previous_weight_next     = '0;
            if (coin != COIN_NONE) begin
              result_next.coin_found = 1'b1;
              result_next.coin_value = coin;
              phase_next             = PH_COOL;
              coin_stamp_next        = in_now;
            end else begin
              result_next.reject = 1'b1;
              phase_next         = PH_WAIT;
            end
          end
        end else begin
          change_stamp_next = in_now;
        end
      end
      PH_COOL: begin
        if (since_coin > {{(StampWidth - CfgWidth){1'b0}}, cool_time}) begin
          phase_next               = PH_WAIT;
          result_next.tare_request = 1'b1;
          previous_weight_next     = '0;
        end
      end
      default: begin
        phase_next = PH_WAIT;
        if (step > {{(WeightWidth + 1 - CfgWidth){1'b0}}, change_threshold}) begin
          phase_next        = PH_DETECT;
          change_stamp_next = in_now;
        end
        previous_weight_next = in_weight;
      end
    endcase
    result_next.phase_now = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= RST_CHANGE_THRESHOLD;
      stable_delta     <= RST_STABLE_DELTA;
      settle_time      <= RST_SETTLE_TIME;
      cool_time        <= RST_COOL_TIME;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_data;
        REG_STABLE_DELTA:     stable_delta     <= cfg_data;
        REG_SETTLE_TIME:      settle_time      <= cfg_data;
        REG_COOL_TIME:        cool_time        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      previous_weight <= '0;
      change_stamp    <= '0;
      coin_stamp      <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      previous_weight <= previous_weight_next;
      change_stamp    <= change_stamp_next;
      coin_stamp      <= coin_stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_weight <= s_tdata[WeightWidth-1:0];
      in_now    <= s_tdata[WeightWidth+StampWidth-1:WeightWidth];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

  // A recognised coin always comes with a tare and moves into cooldown.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.coin_found |->
      out_result.tare_request && out_result.phase_now == PHASE_CODE_COOL)
    else $error("coin result without tare or cooldown");

  // A reject returns to waiting with a tare and never reports a coin.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.reject |->
      out_result.tare_request && !out_result.coin_found &&
      out_result.phase_now == PHASE_CODE_WAIT)
    else $error("reject result inconsistent");

  // The coin value is nonzero exactly when a coin is reported.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.coin_value != COIN_NONE) == out_result.coin_found)
    else $error("coin value and coin flag disagree");

  // A coin taken into the result register leaves the machine in cooldown.
  assert property (@(posedge clk) disable iff (rst)
    advance && result_next.coin_found |=> phase == PH_COOL && coin_stamp == $past(in_now))
    else $error("coin did not start cooldown");

endmodule
